// File: hw/rtl/fhad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDD HARQ-ACK demapper package
// Shared constants, codes and the request bundle of the demapper.
// ----------------------------------------------------------------------------
package fhad_pkg;

   localparam int FIELD_CELLS     = 5;
   localparam int MAX_CELLS       = 5;
   localparam int BLOCKS_PER_CELL = 2;
   localparam int CELL_CAP        = (MAX_CELLS < FIELD_CELLS) ? MAX_CELLS : FIELD_CELLS;

   localparam int ACK_W    = 10;
   localparam int NCELL_W  = 3;
   localparam int STATUS_W = 20;

   localparam logic [1:0] ST_NACK     = 2'd0;
   localparam logic [1:0] ST_NOT_SENT = 2'd2;

   typedef enum logic [1:0] {
      FB_NORMAL = 2'd0,
      FB_CHSEL  = 2'd1,
      FB_FMT3   = 2'd2,
      FB_ERROR  = 2'd3
   } fb_mode_type;

   typedef struct packed {
      logic                 fdd_frame;
      logic [NCELL_W-1:0]   num_cells;
      logic                 multi_block_mode;
      fb_mode_type          feedback_mode;
      logic                 pusch_available;
      logic                 sched_request;
      logic                 csi_pending;
      logic                 ack_valid;
      logic [ACK_W-1:0]     ack_bits;
      logic [FIELD_CELLS-1:0] cell_present;
      logic [STATUS_W-1:0]  block_status;
   } req_type;

endpackage

// File: hw/rtl/fhad_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDD HARQ-ACK mapping logic
// Chooses the ACK mapping for one report and rewrites the block statuses.
// ----------------------------------------------------------------------------
module fhad_map (
   input  fhad_pkg::req_type              req,
   output logic [fhad_pkg::STATUS_W-1:0]  status_out
);

   typedef enum logic [1:0] {
      MAP_NONE   = 2'd0,
      MAP_PCELL  = 2'd1,
      MAP_ALL    = 2'd2,
      MAP_BUNDLE = 2'd3
   } map_sel_type;

   logic [1:0]                          blk_on;
   logic                                two_blk;
   logic [fhad_pkg::NCELL_W-1:0]        ncl;
   logic [fhad_pkg::FIELD_CELLS-1:0][1:0] act;
   logic [1:0]                          pc_act;
   logic [1:0]                          pc_val;
   logic                                other_sent;
   map_sel_type                         map_sel;

   always_comb begin
      two_blk   = req.multi_block_mode && (fhad_pkg::BLOCKS_PER_CELL == 2);
      blk_on[0] = 1'b1;
      blk_on[1] = two_blk;
      if (req.num_cells > fhad_pkg::NCELL_W'(fhad_pkg::CELL_CAP)) begin
         ncl = fhad_pkg::NCELL_W'(fhad_pkg::CELL_CAP);
      end else begin
         ncl = req.num_cells;
      end
      for (int c = 0; c < fhad_pkg::FIELD_CELLS; c++) begin
         for (int b = 0; b < 2; b++) begin
            act[c][b] = req.cell_present[c] && blk_on[b] &&
                        (req.block_status[4*c+2*b +: 2] != fhad_pkg::ST_NOT_SENT) &&
                        (fhad_pkg::NCELL_W'(c) < ncl);
         end
      end
      for (int b = 0; b < 2; b++) begin
         pc_act[b] = req.cell_present[0] && blk_on[b] &&
                     (req.block_status[2*b +: 2] != fhad_pkg::ST_NOT_SENT);
      end
      pc_val[0] = req.ack_valid && req.ack_bits[0];
      pc_val[1] = req.ack_valid && (pc_act[0] ? req.ack_bits[1] : req.ack_bits[0]);
      other_sent = 1'b0;
      for (int c = 1; c < fhad_pkg::FIELD_CELLS; c++) begin
         other_sent = other_sent | act[c][0] | act[c][1];
      end
   end

   always_comb begin
      map_sel = MAP_NONE;
      if (req.fdd_frame) begin
         unique case (req.feedback_mode)
            fhad_pkg::FB_NORMAL: map_sel = MAP_PCELL;
            fhad_pkg::FB_CHSEL: begin
               if (req.num_cells == fhad_pkg::NCELL_W'(1)) begin
                  map_sel = MAP_PCELL;
               end else if (req.pusch_available) begin
                  map_sel = MAP_ALL;
               end else if (req.sched_request) begin
                  map_sel = MAP_BUNDLE;
               end else if (req.csi_pending) begin
                  map_sel = MAP_PCELL;
               end else begin
                  map_sel = MAP_ALL;
               end
            end
            fhad_pkg::FB_FMT3: map_sel = other_sent ? MAP_ALL : MAP_PCELL;
            default: map_sel = MAP_NONE;
         endcase
      end
   end

   always_comb begin
      status_out = req.block_status;
      case (map_sel)
         MAP_PCELL: begin
            for (int b = 0; b < 2; b++) begin
               if (pc_act[b]) begin
                  status_out[2*b +: 2] = {1'b0, pc_val[b]};
               end
            end
         end
         MAP_ALL: begin
            for (int c = 0; c < fhad_pkg::FIELD_CELLS; c++) begin
               for (int b = 0; b < 2; b++) begin
                  if (act[c][b]) begin
                     status_out[4*c+2*b +: 2] =
                        {1'b0, req.ack_valid &&
                               (two_blk ? req.ack_bits[2*c+b] : req.ack_bits[c])};
                  end
               end
            end
         end
         MAP_BUNDLE: begin
            for (int c = 0; c < fhad_pkg::FIELD_CELLS; c++) begin
               for (int b = 0; b < 2; b++) begin
                  if (act[c][b]) begin
                     status_out[4*c+2*b +: 2] = {1'b0, req.ack_bits[c]};
                  end
               end
            end
         end
         default: status_out = req.block_status;
      endcase
   end

endmodule

// File: hw/rtl/fdd_harq_ack_demap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDD HARQ-ACK demapper
// Writes the received ACK/NACK of one uplink control report back into the
// per-cell, per-block transmission statuses.
// ----------------------------------------------------------------------------
// The block takes one report in every clock cycle and never raises busy. A
// report transferred at one clock edge has its result on the rsp_ ports,
// marked by rsp_strobe, for a single cycle, once it has passed the input
// register and the result register around the mapping logic. The receiver
// must take every result in that cycle.
module fdd_harq_ack_demap_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_fdd_frame,
   input  logic [2:0]                         req_num_cells,
   input  logic                               req_multi_block_mode,
   input  logic [1:0]                         req_feedback_mode,
   input  logic                               req_pusch_available,
   input  logic                               req_sched_request,
   input  logic                               req_csi_pending,
   input  logic                               req_ack_valid,
   input  logic [9:0]                         req_ack_bits,
   input  logic [4:0]                         req_cell_present,
   input  logic [19:0]                        req_block_status,
   output logic                               rsp_strobe,
   output logic [19:0]                        rsp_block_status_out
);

   logic                                req_vld_ff;
   logic                                req_vld_in;
   fhad_pkg::req_type                   req_ff;
   fhad_pkg::req_type                   req_in;
   logic                                rsp_vld_ff;
   logic [fhad_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [fhad_pkg::STATUS_W-1:0]       rsp_status_in;

   assign busy       = 1'b0;
   assign req_vld_in = start && !busy;

   always_comb begin
      req_in.fdd_frame        = req_fdd_frame;
      req_in.num_cells        = req_num_cells;
      req_in.multi_block_mode = req_multi_block_mode;
      req_in.feedback_mode    = fhad_pkg::fb_mode_type'(req_feedback_mode);
      req_in.pusch_available  = req_pusch_available;
      req_in.sched_request    = req_sched_request;
      req_in.csi_pending      = req_csi_pending;
      req_in.ack_valid        = req_ack_valid;
      req_in.ack_bits         = req_ack_bits;
      req_in.cell_present     = req_cell_present;
      req_in.block_status     = req_block_status;
   end

   fhad_map u_map (
      .req        (req_ff),
      .status_out (rsp_status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_in) begin
         req_ff <= req_in;
      end
      if (req_vld_ff) begin
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_strobe           = rsp_vld_ff;
   assign rsp_block_status_out = rsp_status_ff;

endmodule

// File: hw/rtl/fhad_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDD HARQ-ACK demapper checker
// Port-level checks on latency and pass-through behavior of the demapper.
// ----------------------------------------------------------------------------
module fhad_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_fdd_frame,
   input  logic [1:0]  req_feedback_mode,
   input  logic [19:0] req_block_status,
   input  logic        rsp_strobe,
   input  logic [19:0] rsp_block_status_out
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised although the receiver cannot stall");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transfer produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> ##1 !rsp_strobe)
      else $error("result strobe without an accepted transfer");

   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (start && !busy &&
       (!req_fdd_frame || req_feedback_mode == fhad_pkg::FB_ERROR))
      |=> ##1 (rsp_block_status_out == $past(req_block_status, 2)))
      else $error("TDD or error-mode report changed the statuses");

endmodule

bind fdd_harq_ack_demap_top fhad_check u_fhad_check (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_fdd_frame        (req_fdd_frame),
   .req_feedback_mode    (req_feedback_mode),
   .req_block_status     (req_block_status),
   .rsp_strobe           (rsp_strobe),
   .rsp_block_status_out (rsp_block_status_out)
);

// File: test/fdd_harq_ack_demap_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDD HARQ-ACK demapper testbench
// Drives directed and random uplink control reports in bursts and checks
// every returned status word against a behavioral model of the three
// ACK/NACK mappings and the mode choice.
// ----------------------------------------------------------------------------
module fdd_harq_ack_demap_top_test;

   import fhad_pkg::*;

   localparam logic [1:0] ST_ACK      = 2'd1;
   localparam logic [1:0] ST_RESERVED = 2'd3;
   localparam int RANDOM_REPORTS = 1628;
   localparam int STALL_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 8;

   typedef enum int {
      MAP_KEEP,
      MAP_PCELL,
      MAP_ALL,
      MAP_BUNDLE
   } map_kind_type;

   typedef struct {
      req_type rpt;
      bit      wait_idle;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        rsp_strobe;
   logic [19:0] rsp_block_status_out;
   req_type     req_drv = '0;

   stim_type    report_q[$];
   logic [19:0] status_exp_q[$];
   stim_type    next_report;
   logic [19:0] status_exp;
   logic        req_taken = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          stall_cycles = 0;
   int          errors = 0;

   fdd_harq_ack_demap_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_fdd_frame        (req_drv.fdd_frame),
      .req_num_cells        (req_drv.num_cells),
      .req_multi_block_mode (req_drv.multi_block_mode),
      .req_feedback_mode    (req_drv.feedback_mode),
      .req_pusch_available  (req_drv.pusch_available),
      .req_sched_request    (req_drv.sched_request),
      .req_csi_pending      (req_drv.csi_pending),
      .req_ack_valid        (req_drv.ack_valid),
      .req_ack_bits         (req_drv.ack_bits),
      .req_cell_present     (req_drv.cell_present),
      .req_block_status     (req_drv.block_status),
      .rsp_strobe           (rsp_strobe),
      .rsp_block_status_out (rsp_block_status_out)
   );

   function automatic logic ack_bit(logic [ACK_W-1:0] bits, int idx);
      return (idx < ACK_W) ? bits[idx] : 1'b0;
   endfunction

   function automatic logic [STATUS_W-1:0] demap_status(req_type r);
      logic [STATUS_W-1:0] st;
      int                  nb;
      int                  ncl;
      int                  sent_all;
      int                  sent_pcell;
      int                  k;
      int                  pos;
      logic                v;
      map_kind_type        kind;
      st = r.block_status;
      nb = r.multi_block_mode ? BLOCKS_PER_CELL : 1;
      if (nb > 2) nb = 2;
      ncl = (r.num_cells > CELL_CAP) ? CELL_CAP : int'(r.num_cells);
      sent_all = 0;
      sent_pcell = 0;
      for (int c = 0; c < ncl; c++) begin
         for (int b = 0; b < nb; b++) begin
            if (r.cell_present[c] && st[(2*c+b)*2 +: 2] != ST_NOT_SENT) begin
               sent_all++;
               if (c == 0) sent_pcell++;
            end
         end
      end
      kind = MAP_KEEP;
      if (r.fdd_frame) begin
         case (r.feedback_mode)
            FB_NORMAL: kind = MAP_PCELL;
            FB_CHSEL: begin
               if (r.num_cells == 1) kind = MAP_PCELL;
               else if (r.pusch_available) kind = MAP_ALL;
               else if (r.sched_request) kind = MAP_BUNDLE;
               else if (r.csi_pending) kind = MAP_PCELL;
               else kind = MAP_ALL;
            end
            FB_FMT3: kind = (sent_all == sent_pcell) ? MAP_PCELL : MAP_ALL;
            default: kind = MAP_KEEP;
         endcase
      end
      if (kind == MAP_PCELL) begin
         // The primary-cell mapping consumes ACK bits in order, one per sent block.
         if (r.cell_present[0]) begin
            k = 0;
            for (int b = 0; b < nb; b++) begin
               if (st[2*b +: 2] != ST_NOT_SENT) begin
                  v = 1'b0;
                  if (r.ack_valid) begin
                     v = ack_bit(r.ack_bits, k);
                     k++;
                  end
                  st[2*b +: 2] = v ? ST_ACK : ST_NACK;
               end
            end
         end
      end else if (kind != MAP_KEEP) begin
         for (int c = 0; c < ncl; c++) begin
            if (r.cell_present[c]) begin
               for (int b = 0; b < nb; b++) begin
                  pos = (2*c + b) * 2;
                  if (st[pos +: 2] != ST_NOT_SENT) begin
                     if (kind == MAP_BUNDLE) v = ack_bit(r.ack_bits, c);
                     else v = r.ack_valid ? ack_bit(r.ack_bits, c*nb + b) : 1'b0;
                     st[pos +: 2] = v ? ST_ACK : ST_NACK;
                  end
               end
            end
         end
      end
      return st;
   endfunction

   function automatic logic [STATUS_W-1:0] rand_status();
      logic [STATUS_W-1:0] st;
      int                  pick;
      st = '0;
      for (int e = 0; e < STATUS_W/2; e++) begin
         pick = $urandom_range(0, 15);
         if (pick < 6) st[2*e +: 2] = ST_NACK;
         else if (pick < 12) st[2*e +: 2] = ST_ACK;
         else if (pick < 15) st[2*e +: 2] = ST_NOT_SENT;
         else st[2*e +: 2] = ST_RESERVED;
      end
      return st;
   endfunction

   function automatic req_type base_report();
      req_type r;
      r = '0;
      r.fdd_frame = 1'b1;
      r.num_cells = 3'd5;
      r.multi_block_mode = 1'b1;
      r.feedback_mode = FB_NORMAL;
      r.ack_valid = 1'b1;
      r.ack_bits = ACK_W'($urandom_range(0, 1023));
      r.cell_present = 5'h1F;
      r.block_status = rand_status();
      return r;
   endfunction

   task automatic add_report(req_type r, bit wait_idle);
      stim_type s;
      s.rpt = r;
      s.wait_idle = wait_idle;
      report_q.push_back(s);
   endtask

   task automatic build_directed();
      req_type r;
      r = base_report(); r.fdd_frame = 1'b0; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_ERROR; add_report(r, 1'b0);
      r = base_report(); r.block_status = '0; r.ack_bits = 10'h3FF; add_report(r, 1'b0);
      r = base_report(); r.ack_valid = 1'b0; r.block_status = 20'hFFFFF;
      add_report(r, 1'b0);
      r = base_report(); r.cell_present = 5'h00; add_report(r, 1'b0);
      r = base_report(); r.num_cells = 3'd0; r.multi_block_mode = 1'b0;
      add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.num_cells = 3'd1;
      r.pusch_available = 1'b1; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.pusch_available = 1'b1;
      add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.num_cells = 3'd3;
      r.sched_request = 1'b1; r.ack_valid = 1'b0; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.num_cells = 3'd4;
      r.csi_pending = 1'b1; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.num_cells = 3'd2;
      r.ack_valid = 1'b0; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.num_cells = 3'd2;
      add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_FMT3; r.block_status = 20'hAAAA4;
      add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_FMT3; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.num_cells = 3'd7;
      r.pusch_available = 1'b1; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_FMT3; r.num_cells = 3'd6;
      add_report(r, 1'b0);
      r = base_report(); r.block_status = 20'hAAAAA; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.multi_block_mode = 1'b0;
      add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.multi_block_mode = 1'b0;
      r.sched_request = 1'b1; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_CHSEL; r.ack_bits = '0;
      r.block_status = 20'h55555; add_report(r, 1'b0);
      r = base_report(); r.feedback_mode = FB_FMT3; r.num_cells = 3'd0;
      add_report(r, 1'b0);
   endtask

   task automatic build_random();
      req_type r;
      for (int i = 0; i < RANDOM_REPORTS; i++) begin
         r.fdd_frame = ($urandom_range(0, 9) != 0);
         r.num_cells = NCELL_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                            : $urandom_range(1, 5));
         r.multi_block_mode = 1'($urandom_range(0, 1));
         r.feedback_mode = fb_mode_type'($urandom_range(0, 3));
         r.pusch_available = 1'($urandom_range(0, 1));
         r.sched_request = 1'($urandom_range(0, 1));
         r.csi_pending = 1'($urandom_range(0, 1));
         r.ack_valid = ($urandom_range(0, 4) != 0);
         r.ack_bits = ACK_W'($urandom_range(0, 1023));
         r.cell_present = FIELD_CELLS'($urandom_range(0, 31));
         r.block_status = ($urandom_range(0, 7) == 0)
                          ? STATUS_W'($urandom_range(0, 20'hFFFFF))
                          : rand_status();
         if ($urandom_range(0, 3) == 0) r.block_status[19:4] = 16'hAAAA;
         add_report(r, (i == 0) || ($urandom_range(0, 199) == 0));
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (report_q.size() == 0 ||
                   (report_q[0].wait_idle && status_exp_q.size() != 0)) begin
         start <= 1'b0;
      end else begin
         next_report = report_q.pop_front();
         req_drv <= next_report.rpt;
         start <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (status_exp_q.size() == 0) begin
               $error("unexpected result transfer, block_status_out %05h",
                      rsp_block_status_out);
               errors++;
            end else begin
               status_exp = status_exp_q.pop_front();
               if (rsp_block_status_out !== status_exp) begin
                  $error("block_status_out: expected %05h, actual %05h",
                         status_exp, rsp_block_status_out);
                  errors++;
               end
            end
         end
         if (start && !busy) status_exp_q.push_back(demap_status(req_drv));
      end
      req_taken <= start && !busy;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      build_directed();
      build_random();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (report_q.size() != 0 || start) @(posedge clock);
      while (status_exp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
